>>> rtl/pdfm_pkg.sv
package pdfm_pkg;

  localparam int CNT_W  = 16;  // tick counter and capture width
  localparam int CLK_W  = 24;  // clock_hz register
  localparam int CODE_W = 3;   // prescale code
  localparam int PSC_W  = 10;  // prescaler count
  localparam int SHF_W  = 4;   // prescaler shift amount
  localparam int DUTY_W = 7;
  localparam int NUM_W  = 24;  // divider dividend and quotient
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int IDX_W  = ADDR_W - 2;

  localparam logic [NUM_W-1:0] DUTY_SCALE   = NUM_W'(100);
  localparam logic [CLK_W-1:0] CLOCK_HZ_RST = CLK_W'(16000000);

  // register indexes (byte address = 4 * index)
  localparam logic [IDX_W-1:0] REG_CLOCK_HZ = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PRESCALE = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_RUN      = IDX_W'(2);

  // prescale codes
  localparam logic [CODE_W-1:0] PSC_DIV8    = CODE_W'(1);
  localparam logic [CODE_W-1:0] PSC_DIV64   = CODE_W'(2);
  localparam logic [CODE_W-1:0] PSC_DIV256  = CODE_W'(3);
  localparam logic [CODE_W-1:0] PSC_DIV1024 = CODE_W'(4);

  typedef struct packed {
    logic [CLK_W-1:0]  clock_hz;
    logic [CODE_W-1:0] prescale_code;
    logic              run_enable;
    logic              recalc;    // clock or prescale written
  } cfg_t;

  typedef struct packed {
    logic take;        // input request accepted this cycle
    logic div_start;
    logic div_freq;    // 1: frequency operands, 0: duty operands
    logic store_duty;
    logic store_freq;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cap;         // current request captures an edge
    logic div_done;
  } sts_t;

  // divisor minus one
  function automatic logic [PSC_W-1:0] psc_limit(input logic [CODE_W-1:0] code);
    logic [PSC_W-1:0] lim;
    unique case (code)
      PSC_DIV8:    lim = PSC_W'(7);
      PSC_DIV64:   lim = PSC_W'(63);
      PSC_DIV256:  lim = PSC_W'(255);
      PSC_DIV1024: lim = PSC_W'(1023);
      default:     lim = '0;
    endcase
    return lim;
  endfunction

  // log2 of divisor
  function automatic logic [SHF_W-1:0] psc_shift(input logic [CODE_W-1:0] code);
    logic [SHF_W-1:0] sh;
    unique case (code)
      PSC_DIV8:    sh = SHF_W'(3);
      PSC_DIV64:   sh = SHF_W'(6);
      PSC_DIV256:  sh = SHF_W'(8);
      PSC_DIV1024: sh = SHF_W'(10);
      default:     sh = '0;
    endcase
    return sh;
  endfunction

endpackage

>>> rtl/pdfm_regs.sv
module pdfm_regs import pdfm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [CLK_W-1:0]  clock_hz_r;
  logic [CODE_W-1:0] prescale_r;
  logic              run_r;
  logic              recalc_r;
  logic              wr;
  logic [IDX_W-1:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= CLOCK_HZ_RST;
      prescale_r <= '0;
      run_r      <= 1'b0;
      recalc_r   <= 1'b0;
    end else begin
      recalc_r <= 1'b0;
      if (wr) begin
        priority if (idx == REG_CLOCK_HZ) begin
          clock_hz_r <= pwdata[CLK_W-1:0];
          recalc_r   <= 1'b1;
        end else if (idx == REG_PRESCALE) begin
          prescale_r <= pwdata[CODE_W-1:0];
          recalc_r   <= 1'b1;
        end else if (idx == REG_RUN) begin
          run_r <= pwdata[0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    priority if (idx == REG_CLOCK_HZ) begin
      prdata = DATA_W'(clock_hz_r);
    end else if (idx == REG_PRESCALE) begin
      prdata = DATA_W'(prescale_r);
    end else if (idx == REG_RUN) begin
      prdata = DATA_W'(run_r);
    end
  end

  assign cfg.clock_hz      = clock_hz_r;
  assign cfg.prescale_code = prescale_r;
  assign cfg.run_enable    = run_r;
  assign cfg.recalc        = recalc_r;

endmodule

>>> rtl/pdfm_div.sv
module pdfm_div import pdfm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [CNT_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  localparam int ITER_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  den_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    sh;
  logic              ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    sh      = {rem_r, quo_r[NUM_W-1]};
    ge      = sh >= {1'b0, den_r};
    rem_nxt = ge ? CNT_W'(sh - {1'b0, den_r}) : sh[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ITER_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - ITER_W'(1);
        if (cnt_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

>>> rtl/pdfm_datapath.sv
module pdfm_datapath import pdfm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_signal_level,
  input  logic              in_clear_count,
  input  cfg_t              cfg,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic [CNT_W-1:0]  out_count_value,
  output logic [DUTY_W-1:0] out_duty_percent,
  output logic [CLK_W-1:0]  out_frequency_hz,
  output logic              out_status
);

  logic [CNT_W-1:0]  tick_r, tick_nxt;
  logic [PSC_W-1:0]  psc_r, psc_nxt;
  logic              phase_r, phase_nxt;
  logic              prev_r;
  logic [CNT_W-1:0]  low_r, low_nxt;
  logic [CNT_W-1:0]  period_r, period_nxt;
  logic              cap_low, cap_per, carry, clr;
  logic [DUTY_W-1:0] duty_r;
  logic [CLK_W-1:0]  freq_r;
  logic [CNT_W-1:0]  diff;
  logic [NUM_W-1:0]  num_duty, num_freq, div_num;
  logic [NUM_W-1:0]  div_q;
  logic              div_done;
  logic              complete;

  always_comb begin
    cap_low    = !phase_r & !prev_r & in_signal_level;
    cap_per    = phase_r & prev_r & !in_signal_level;
    low_nxt    = cap_low ? tick_r : low_r;
    period_nxt = cap_per ? tick_r : period_r;
    phase_nxt  = cap_low | (phase_r & !cap_per);

    carry   = 1'b0;
    psc_nxt = psc_r;
    if (cfg.run_enable) begin
      if (psc_r >= psc_limit(cfg.prescale_code)) begin
        psc_nxt = '0;
        carry   = 1'b1;
      end else begin
        psc_nxt = psc_r + PSC_W'(1);
      end
    end

    // a period capture or a count clear restarts the count and swallows this tick's carry
    clr = in_clear_count | cap_per;
    priority if (clr) begin
      tick_nxt = '0;
    end else if (carry) begin
      tick_nxt = tick_r + CNT_W'(1);
    end else begin
      tick_nxt = tick_r;
    end
  end

  assign sts.cap = cap_low | cap_per;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      psc_r    <= '0;
      phase_r  <= 1'b0;
      prev_r   <= 1'b0;
      low_r    <= '0;
      period_r <= '0;
    end else if (cmd.take) begin
      tick_r   <= tick_nxt;
      psc_r    <= psc_nxt;
      phase_r  <= phase_nxt;
      prev_r   <= in_signal_level;
      low_r    <= low_nxt;
      period_r <= period_nxt;
    end
  end

  // divider operands; low above period gives zero duty
  always_comb begin
    diff     = (period_r > low_r) ? (period_r - low_r) : '0;
    num_duty = NUM_W'(NUM_W'(diff) * DUTY_SCALE);
    num_freq = NUM_W'(cfg.clock_hz >> psc_shift(cfg.prescale_code));
    div_num  = cmd.div_freq ? num_freq : num_duty;
  end

  pdfm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (period_r),
    .quo   (div_q),
    .done  (div_done)
  );

  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.store_duty) begin
      duty_r <= div_q[DUTY_W-1:0];
    end
    if (cmd.store_freq) begin
      freq_r <= div_q[CLK_W-1:0];
    end
  end

  assign complete = (low_r != '0) && (period_r != '0);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_count_value  <= cmd.take ? tick_nxt : tick_r;
      out_duty_percent <= complete ? duty_r : '0;
      out_frequency_hz <= complete ? freq_r : '0;
      out_status       <= !complete;
    end
  end

endmodule

>>> rtl/pdfm_ctrl.sv
module pdfm_ctrl import pdfm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  cfg_t cfg,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DUTY_GO  = 5'b00010,
    S_DUTY_RUN = 5'b00100,
    S_FREQ_RUN = 5'b01000,
    S_DONE     = 5'b10000
  } state_t;

  state_t st_r, st_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   dirty_r, dirty_nxt;
  logic   pend_r, pend_nxt;
  logic   out_free;

  assign out_free = !out_valid_r | out_ready;

  always_comb begin
    st_nxt   = st_r;
    pend_nxt = pend_r;
    cmd      = '0;
    in_ready = 1'b0;
    dirty_nxt = dirty_r;
    unique case (st_r)
      S_IDLE: begin
        // hold off while a config write is still on its way to dirty_r
        in_ready = !dirty_r & !cfg.recalc & out_free;
        cmd.take = in_valid & in_ready;
        if (dirty_r) begin
          // config changed: refresh the stored results, nothing to deliver
          dirty_nxt = 1'b0;
          pend_nxt  = 1'b0;
          st_nxt    = S_DUTY_GO;
        end else if (cmd.take) begin
          if (sts.cap) begin
            pend_nxt = 1'b1;
            st_nxt   = S_DUTY_GO;
          end else begin
            cmd.load_out = 1'b1;
          end
        end
      end
      S_DUTY_GO: begin
        cmd.div_start = 1'b1;
        st_nxt        = S_DUTY_RUN;
      end
      S_DUTY_RUN: begin
        if (sts.div_done) begin
          cmd.store_duty = 1'b1;
          cmd.div_start  = 1'b1;
          cmd.div_freq   = 1'b1;
          st_nxt         = S_FREQ_RUN;
        end
      end
      S_FREQ_RUN: begin
        if (sts.div_done) begin
          cmd.store_freq = 1'b1;
          st_nxt         = pend_r ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          st_nxt       = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    if (cfg.recalc) begin
      dirty_nxt = 1'b1;
    end
    out_valid_nxt = cmd.load_out | (out_valid_r & !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      dirty_r     <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      dirty_r     <= dirty_nxt;
      pend_r      <= pend_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_cap_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && sts.cap |=> st_r == S_DUTY_GO)
    else $error("capture did not start a recalculation");

  a_plain_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && !sts.cap |=> out_valid_r && st_r == S_IDLE)
    else $error("plain request not delivered next cycle");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (st_r == S_DUTY_RUN || st_r == S_FREQ_RUN))
    else $error("divider finished while not awaited");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DUTY_GO |=> !cmd.take)
    else $error("request accepted during recalculation");
`endif

endmodule

>>> rtl/pwm_input_duty_frequency_meter_core.sv
// PWM input meter: one request per system clock tick carries the sampled signal level and a
// counter clear; every request returns the tick count, and once a low time and a period have
// both been captured, the duty in percent and the frequency in hertz. A request that captures
// no edge is answered in the following cycle, and the next request can follow at once unless
// output is stalled. A request that captures a rising or falling edge holds off input while
// one shared 24-step restoring divider works out the duty and then the frequency; a write to
// clock_hz or prescale_code runs the same recalculation before the next request is taken.
module pwm_input_duty_frequency_meter_core import pdfm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_signal_level,
  input  logic              in_clear_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CNT_W-1:0]  out_count_value,
  output logic [DUTY_W-1:0] out_duty_percent,
  output logic [CLK_W-1:0]  out_frequency_hz,
  output logic              out_status,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  pdfm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pdfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg       (cfg),
    .sts       (sts),
    .cmd       (cmd)
  );

  pdfm_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_signal_level  (in_signal_level),
    .in_clear_count   (in_clear_count),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .out_count_value  (out_count_value),
    .out_duty_percent (out_duty_percent),
    .out_frequency_hz (out_frequency_hz),
    .out_status       (out_status)
  );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pdfm_pkg::*;

  localparam int HOLD_CYCLES   = 300;   // long receiver stall
  localparam int SETTLE_CYCLES = 80;    // covers the edge/recalc divider pass
  localparam int RAND_REQS     = 750;
  localparam int PERCENT       = 100;

  // prescale codes not named in the package
  localparam logic [CODE_W-1:0] PSC_DIV1   = CODE_W'(0);
  localparam logic [CODE_W-1:0] PSC_SPARE5 = CODE_W'(5);
  localparam logic [CODE_W-1:0] PSC_SPARE6 = CODE_W'(6);
  localparam logic [CODE_W-1:0] PSC_SPARE7 = CODE_W'(7);

  typedef enum logic {WAIT_RISE, WAIT_FALL} cap_phase_t;
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count_value;
    logic [DUTY_W-1:0] duty_percent;
    logic [CLK_W-1:0]  frequency_hz;
    logic              status;
  } meter_rdg_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              level;
    logic              clear;
    logic [15:0]       reps;
    logic              has_rdg;
    meter_rdg_t        rdg;
    logic [IDX_W-1:0]  reg_idx;
    logic [DATA_W-1:0] reg_val;
  } step_t;

  localparam meter_rdg_t IDLE_RDG = '{CNT_W'(0), DUTY_W'(0), CLK_W'(0), 1'b1};
  // period of one tick at full clock, low time above period
  localparam meter_rdg_t FAST_RDG = '{CNT_W'(0), DUTY_W'(0), CLK_W'(16000000), 1'b0};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_signal_level = 1'b0;
  logic              in_clear_count = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CNT_W-1:0]  out_count_value;
  logic [DUTY_W-1:0] out_duty_percent;
  logic [CLK_W-1:0]  out_frequency_hz;
  logic              out_status;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // predictor state and register copy
  logic [CLK_W-1:0]  set_clock_hz = CLOCK_HZ_RST;
  logic [CODE_W-1:0] set_code = PSC_DIV1;
  logic              set_run = 1'b0;
  logic [CNT_W-1:0]  meas_tick = '0;
  logic [PSC_W-1:0]  meas_psc = '0;
  cap_phase_t        meas_phase = WAIT_RISE;
  logic              meas_prev = 1'b0;
  logic [CNT_W-1:0]  meas_low = '0;
  logic [CNT_W-1:0]  meas_period = '0;

  meter_rdg_t        pending_rdgs[$];
  logic              typed_valid = 1'b0;
  meter_rdg_t        typed_rdg = '0;
  logic              gaps_on = 1'b1;
  logic              hold_req = 1'b0;
  int                errors = 0;

  pwm_input_duty_frequency_meter_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_signal_level(in_signal_level), .in_clear_count(in_clear_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_count_value(out_count_value), .out_duty_percent(out_duty_percent),
    .out_frequency_hz(out_frequency_hz), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned prescale_ratio(input logic [CODE_W-1:0] code);
    case (code)
      PSC_DIV8:    return 8;
      PSC_DIV64:   return 64;
      PSC_DIV256:  return 256;
      PSC_DIV1024: return 1024;
      default:     return 1;
    endcase
  endfunction

  // one tick of the meter: edge capture, prescaler, counter, then the readings
  function automatic meter_rdg_t meter_tick(input logic lvl, input logic clr);
    meter_rdg_t  r;
    logic        rising;
    logic        falling;
    logic        carry;
    logic        zero_cnt;
    int unsigned ratio;
    rising   = !meas_prev && lvl;
    falling  = meas_prev && !lvl;
    zero_cnt = clr;
    carry    = 1'b0;
    ratio    = prescale_ratio(set_code);
    if (meas_phase == WAIT_RISE) begin
      if (rising) begin
        meas_low   = meas_tick;
        meas_phase = WAIT_FALL;
      end
    end else if (falling) begin
      meas_period = meas_tick;
      meas_phase  = WAIT_RISE;
      zero_cnt    = 1'b1;
    end
    meas_prev = lvl;
    if (set_run) begin
      if (meas_psc >= ratio - 1) begin
        meas_psc = '0;
        carry    = 1'b1;
      end else begin
        meas_psc = meas_psc + 1'b1;
      end
    end
    if (zero_cnt) meas_tick = '0;
    else if (carry) meas_tick = meas_tick + 1'b1;
    r = '{meas_tick, DUTY_W'(0), CLK_W'(0), 1'b1};
    if (meas_low != 0 && meas_period != 0) begin
      r.status = 1'b0;
      if (meas_period > meas_low)
        r.duty_percent = DUTY_W'(32'(meas_period - meas_low) * PERCENT / 32'(meas_period));
      r.frequency_hz = CLK_W'((32'(set_clock_hz) / ratio) / 32'(meas_period));
    end
    return r;
  endfunction

  task automatic check_field(input string fld, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, fld, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    meter_rdg_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = meter_tick(in_signal_level, in_clear_count);
        if (typed_valid) want = typed_rdg;
        pending_rdgs.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_rdgs.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, got count %0d",
                   $time, out_count_value);
          errors++;
        end else begin
          want = pending_rdgs.pop_front();
          check_field("count_value", 32'(want.count_value), 32'(out_count_value));
          check_field("duty_percent", 32'(want.duty_percent), 32'(out_duty_percent));
          check_field("frequency_hz", 32'(want.frequency_hz), 32'(out_frequency_hz));
          check_field("status", 32'(want.status), 32'(out_status));
        end
      end
    end
  end

  // result side: random back-pressure, plus one long stall on request
  initial begin : receiver
    int stall;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (stall = 0; stall < HOLD_CYCLES; stall++) @(negedge clk);
      end
      out_ready <= !(gaps_on && ($urandom_range(99) < 35));
    end
  end

  // called and returns at a falling edge; valid is left high for the next request
  task automatic send_req(input logic lvl, input logic clr,
                          input logic has_rdg = 1'b0, input meter_rdg_t rdg = '0);
    while (gaps_on && ($urandom_range(99) < 35)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    typed_valid = has_rdg;
    typed_rdg   = rdg;
    in_valid        <= 1'b1;
    in_signal_level <= lvl;
    in_clear_count  <= clr;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_rdgs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write, then read back
  task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] rb;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CLOCK_HZ: begin
        set_clock_hz = val[CLK_W-1:0];
        rb = DATA_W'(set_clock_hz);
      end
      REG_PRESCALE: begin
        set_code = val[CODE_W-1:0];
        rb = DATA_W'(set_code);
      end
      default: begin
        set_run = val[0];
        rb = DATA_W'(set_run);
      end
    endcase
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== rb) begin
      $display("%0t: register %0d readback mismatch: expected %0h, got %0h",
               $time, idx, rb, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic step_t req_row(input logic lvl, input logic clr, input int reps);
    return '{ROW_REQ, lvl, clr, 16'(reps), 1'b0, meter_rdg_t'(0), IDX_W'(0), DATA_W'(0)};
  endfunction

  function automatic step_t chk_row(input logic lvl, input logic clr, input meter_rdg_t rdg);
    return '{ROW_REQ, lvl, clr, 16'(1), 1'b1, rdg, IDX_W'(0), DATA_W'(0)};
  endfunction

  function automatic step_t cfg_row(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    return '{ROW_CFG, 1'b0, 1'b0, 16'(0), 1'b0, meter_rdg_t'(0), idx, val};
  endfunction

  initial begin : stimulus
    step_t             steps [27];
    logic [DATA_W-1:0] clk_val;
    logic [CODE_W-1:0] code;
    int                phase;
    int                rand_reqs;
    int                burst;
    int                low_len;
    int                high_len;

    steps = '{
      chk_row(1'b0, 1'b0, IDLE_RDG),
      chk_row(1'b1, 1'b0, IDLE_RDG),       // rising edge while stopped
      chk_row(1'b0, 1'b0, IDLE_RDG),       // falling edge while stopped, zero period
      cfg_row(REG_RUN, DATA_W'(1)),
      req_row(1'b0, 1'b0, 3),
      req_row(1'b1, 1'b0, 2),
      req_row(1'b1, 1'b1, 1),              // clear in the high phase: low > period
      req_row(1'b1, 1'b0, 1),
      chk_row(1'b0, 1'b0, FAST_RDG),
      req_row(1'b0, 1'b0, 3),
      req_row(1'b1, 1'b0, 4),
      req_row(1'b0, 1'b0, 1),
      cfg_row(REG_CLOCK_HZ, DATA_W'(0)),
      req_row(1'b0, 1'b0, 1),
      cfg_row(REG_CLOCK_HZ, 32'hFFFF_FFFF),
      req_row(1'b1, 1'b1, 1),              // capture and clear on the same tick
      cfg_row(REG_PRESCALE, DATA_W'(PSC_DIV1024)),
      req_row(1'b0, 1'b0, 8),
      cfg_row(REG_PRESCALE, DATA_W'(PSC_DIV8)),  // prescaler already past the new limit
      req_row(1'b0, 1'b0, 3),
      cfg_row(REG_PRESCALE, 32'hFFFF_FFF8 | DATA_W'(PSC_SPARE7)),
      req_row(1'b1, 1'b0, 2),
      req_row(1'b0, 1'b0, 1),
      cfg_row(REG_RUN, DATA_W'(0)),
      req_row(1'b1, 1'b1, 1),
      req_row(1'b0, 1'b0, 1),
      cfg_row(REG_RUN, 32'hFFFF_FFFF)
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_CFG) begin
        settle();
        reg_write(steps[i].reg_idx, steps[i].reg_val);
      end else begin
        repeat (steps[i].reps)
          send_req(steps[i].level, steps[i].clear, steps[i].has_rdg, steps[i].rdg);
      end
    end

    phase = 0;
    rand_reqs = 0;
    while (rand_reqs < RAND_REQS) begin
      settle();
      gaps_on = (phase != 2);
      if ($urandom_range(1)) begin
        case ($urandom_range(4))
          0:       clk_val = DATA_W'(CLOCK_HZ_RST);
          1:       clk_val = DATA_W'(1);
          2:       clk_val = DATA_W'(24'hFF_FFFF);
          3:       clk_val = $urandom;
          default: clk_val = $urandom_range(1000, 16000000);
        endcase
        reg_write(REG_CLOCK_HZ, clk_val);
      end
      if ($urandom_range(2) != 0) begin
        case ($urandom_range(9))
          5:       code = $urandom_range(1) ? PSC_SPARE5 : PSC_SPARE6;
          6:       code = PSC_SPARE7;
          7:       code = PSC_DIV8;
          8:       code = PSC_DIV64;
          9:       code = $urandom_range(1) ? PSC_DIV256 : PSC_DIV1024;
          default: code = PSC_DIV1;
        endcase
        reg_write(REG_PRESCALE, DATA_W'(code));
      end
      if ($urandom_range(1))
        reg_write(REG_RUN, DATA_W'($urandom_range(99) < 75));
      if (phase == 3) hold_req = 1'b1;

      burst = 0;
      while (burst < 60) begin
        if ($urandom_range(99) < 75) begin
          // one pwm period, mostly short, now and then long
          low_len  = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 300);
          high_len = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 300);
          repeat (low_len) send_req(1'b0, $urandom_range(99) < 3);
          repeat (high_len) send_req(1'b1, $urandom_range(99) < 3);
          burst += low_len + high_len;
        end else begin
          repeat (6) send_req($urandom_range(1), $urandom_range(1));
          burst += 6;
        end
      end
      rand_reqs += burst;
      phase++;
    end

    in_valid <= 1'b0;
    while (pending_rdgs.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/pdfm_pkg.sv
rtl/pdfm_regs.sv
rtl/pdfm_div.sv
rtl/pdfm_datapath.sv
rtl/pdfm_ctrl.sv
rtl/pwm_input_duty_frequency_meter_core.sv
test/tb_top.sv
